FILE: hw/rtl/sva_pkg.sv
// ----------------------------------------------------------------------------
// Voice allocator package
// Event codes, mode codes, field widths and the result word shared by the
// allocator's modules.
// ----------------------------------------------------------------------------
package sva_pkg;

   localparam int OPCODE_W = 2;
   localparam int TONE_W   = 7;
   localparam int MODE_W   = 2;
   localparam int VOICE_W  = 4;
   localparam int MASK_W   = 16;

   // event codes
   localparam logic [OPCODE_W-1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_ALL_OFF  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_IGNORED  = 2'd3;

   // voice modes; the spare code behaves as polyphonic
   localparam logic [MODE_W-1:0] MODE_POLY    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MONO    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ONESHOT = 2'd2;

   typedef struct packed {
      logic [VOICE_W-1:0] assigned_voice;
      logic               assigned_valid;
      logic               note_dropped;
      logic [MASK_W-1:0]  released_mask;
      logic [MASK_W-1:0]  active_mask;
   } rsp_word_type;

endpackage

FILE: hw/rtl/sva_event.sv
// ----------------------------------------------------------------------------
// Voice allocator event logic
// Applies one note event to the voice table: tone match, release, first-free
// priority search and the result word, all in one combinational pass.
// ----------------------------------------------------------------------------
module sva_event #(
   parameter int NUM_VOICES = 16
) (
   input  logic [sva_pkg::OPCODE_W-1:0] opcode,
   input  logic [sva_pkg::TONE_W-1:0]   note_tone,
   input  logic [sva_pkg::MODE_W-1:0]   voice_mode,
   input  logic [NUM_VOICES-1:0]        active_cur,
   input  logic [sva_pkg::TONE_W-1:0]   tone_cur [NUM_VOICES],
   output logic [NUM_VOICES-1:0]        active_nxt,
   output logic                         tone_we,
   output logic [((NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1)-1:0] tone_waddr,
   output sva_pkg::rsp_word_type        rsp_word
);

   localparam int VoiceIdxW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int WideMaskW = (NUM_VOICES > sva_pkg::MASK_W) ? NUM_VOICES : sva_pkg::MASK_W;
   localparam int WideIdxW  = (VoiceIdxW > sva_pkg::VOICE_W) ? VoiceIdxW : sva_pkg::VOICE_W;

   logic [NUM_VOICES-1:0] tone_match;
   logic [NUM_VOICES-1:0] release_bits;
   logic [NUM_VOICES-1:0] active_rel;
   logic [VoiceIdxW-1:0]  free_idx;
   logic                  free_found;
   logic                  is_on;
   logic [WideMaskW-1:0]  rel_wide;
   logic [WideMaskW-1:0]  act_wide;
   logic [WideIdxW-1:0]   idx_wide;

   // compare every active voice against the event tone
   always_comb begin
      for (int v = 0; v < NUM_VOICES; v++) begin
         tone_match[v] = active_cur[v] && (tone_cur[v] == note_tone);
      end
   end

   // pick the voices this event releases
   always_comb begin
      is_on = 1'b0;
      case (opcode)
         sva_pkg::OP_NOTE_ON: begin
            is_on        = 1'b1;
            release_bits = (voice_mode == sva_pkg::MODE_MONO) ? tone_match : '0;
         end
         sva_pkg::OP_NOTE_OFF: begin
            release_bits = (voice_mode == sva_pkg::MODE_ONESHOT) ? '0 : tone_match;
         end
         sva_pkg::OP_ALL_OFF: begin
            release_bits = active_cur;
         end
         sva_pkg::OP_IGNORED: begin
            release_bits = '0;
         end
         default: begin
            release_bits = '0;
         end
      endcase
   end

   assign active_rel = active_cur & ~release_bits;

   // lowest-numbered free voice wins
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int v = NUM_VOICES - 1; v >= 0; v--) begin
         if (!active_rel[v]) begin
            free_idx   = VoiceIdxW'(v);
            free_found = 1'b1;
         end
      end
   end

   // claim the voice on a successful note-on
   always_comb begin
      active_nxt = active_rel;
      if (is_on && free_found) begin
         active_nxt[free_idx] = 1'b1;
      end
   end

   assign tone_we    = is_on && free_found;
   assign tone_waddr = free_idx;

   // fold the voice vectors down to the reported widths
   assign rel_wide = WideMaskW'(release_bits);
   assign act_wide = WideMaskW'(active_nxt);
   assign idx_wide = (is_on && free_found) ? WideIdxW'(free_idx) : '0;

   always_comb begin
      rsp_word.assigned_voice = idx_wide[sva_pkg::VOICE_W-1:0];
      rsp_word.assigned_valid = is_on && free_found;
      rsp_word.note_dropped   = is_on && !free_found;
      rsp_word.released_mask  = rel_wide[sva_pkg::MASK_W-1:0];
      rsp_word.active_mask    = act_wide[sva_pkg::MASK_W-1:0];
   end

endmodule

FILE: hw/rtl/synth_voice_allocator.sv
// ----------------------------------------------------------------------------
// Synthesizer voice allocator
// First-free polyphonic voice allocator with monophonic and one-shot modes.
// ----------------------------------------------------------------------------
// The block takes one note event word per clock while the output side keeps
// up, and returns exactly one result word per event. An accepted event is
// held in the input register, applied to the voice table by a single pass of
// tone compare and first-free priority search, and its result is loaded into
// the output register when that register is free or being emptied, so a new
// event can be taken every cycle while the output side keeps up. A stalled
// result holds the input stage; the input side then stops once that stage is
// full.
// The voice mode register is written through the csr_ port; the user must
// write it only while no events are in flight, as the block does not enforce it.
module synth_voice_allocator #(
   parameter int NUM_VOICES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sva_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [sva_pkg::TONE_W-1:0]    req_note_tone,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sva_pkg::VOICE_W-1:0]   rsp_assigned_voice,
   output logic                          rsp_assigned_valid,
   output logic                          rsp_note_dropped,
   output logic [sva_pkg::MASK_W-1:0]    rsp_released_mask,
   output logic [sva_pkg::MASK_W-1:0]    rsp_active_mask,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sva_pkg::MODE_W-1:0]    csr_voice_mode
);

   localparam int VoiceIdxW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int WideMaskW = (NUM_VOICES > sva_pkg::MASK_W) ? NUM_VOICES : sva_pkg::MASK_W;

   logic [sva_pkg::MODE_W-1:0]   mode_ff;
   logic                         in_valid_ff;
   logic [sva_pkg::OPCODE_W-1:0] in_opcode_ff;
   logic [sva_pkg::TONE_W-1:0]   in_tone_ff;
   logic                         rsp_valid_ff;
   sva_pkg::rsp_word_type        rsp_word_ff;
   sva_pkg::rsp_word_type        rsp_word_in;
   logic [NUM_VOICES-1:0]        voice_active_ff;
   logic [NUM_VOICES-1:0]        voice_active_in;
   logic [sva_pkg::TONE_W-1:0]   voice_tone_ff [NUM_VOICES];
   logic                         tone_we;
   logic [VoiceIdxW-1:0]         tone_waddr;
   logic                         advance;
   logic [WideMaskW-1:0]         active_wide;

   // the stage moves on when the output register is free or being emptied
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // hold the voice mode
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sva_pkg::MODE_POLY;
      end else if (csr_valid) begin
         mode_ff <= csr_voice_mode;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_opcode_ff <= req_opcode;
         in_tone_ff   <= req_note_tone;
      end
   end

   sva_event #(
      .NUM_VOICES (NUM_VOICES)
   ) u_event (
      .opcode     (in_opcode_ff),
      .note_tone  (in_tone_ff),
      .voice_mode (mode_ff),
      .active_cur (voice_active_ff),
      .tone_cur   (voice_tone_ff),
      .active_nxt (voice_active_in),
      .tone_we    (tone_we),
      .tone_waddr (tone_waddr),
      .rsp_word   (rsp_word_in)
   );

   // advance the voice table on each processed event
   always_ff @(posedge clock) begin
      if (reset) begin
         voice_active_ff <= '0;
      end else if (in_valid_ff && advance) begin
         voice_active_ff <= voice_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance && tone_we) begin
         voice_tone_ff[tone_waddr] <= in_tone_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_assigned_voice = rsp_word_ff.assigned_voice;
   assign rsp_assigned_valid = rsp_word_ff.assigned_valid;
   assign rsp_note_dropped   = rsp_word_ff.note_dropped;
   assign rsp_released_mask  = rsp_word_ff.released_mask;
   assign rsp_active_mask    = rsp_word_ff.active_mask;

   assign active_wide = WideMaskW'(voice_active_ff);

   // a word cannot both claim a voice and be dropped
   a_assign_xor_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_word_ff.assigned_valid && rsp_word_ff.note_dropped))
      else $error("result both assigned and dropped");

   // a held event stays in the input stage
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_opcode_ff))
      else $error("input stage lost a stalled event");

   // the reported mask matches the voice table just written
   a_mask_matches: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance |=>
         rsp_word_ff.active_mask == active_wide[sva_pkg::MASK_W-1:0])
      else $error("active mask differs from voice table");

   // a dropped note leaves the voice table alone
   a_drop_no_change: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance && rsp_word_in.note_dropped |=>
         voice_active_ff == $past(voice_active_ff))
      else $error("dropped note changed the voice table");

endmodule

FILE: bench/synth_voice_allocator_tb.sv
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives note event words into the allocator and checks every result word
// against a cycle-free model of the voice table. A short table of directed
// events covers the corner cases, then random events run under each voice
// mode. The sender works in bursts, the receiver stalls on a pattern of its
// own, and the mode register is rewritten only while nothing is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module synth_voice_allocator_tb;

   localparam int                         VOICES          = 16;
   localparam int                         EVENTS_PER_MODE = 200;
   localparam int                         CYCLE_LIMIT     = 400000;
   localparam int                         DRAIN_CYCLES    = 8;
   localparam logic [sva_pkg::MODE_W-1:0] MODE_SPARE      = 2'd3;

   typedef logic [sva_pkg::MASK_W-1:0] field_type;

   typedef struct packed {
      logic                         is_mode;
      logic [sva_pkg::OPCODE_W-1:0] code;
      logic [sva_pkg::TONE_W-1:0]   tone;
      logic [4:0]                   repeats;
      logic                         pinned;
      sva_pkg::rsp_word_type        report;
   } plan_row_type;

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic                         req_ready;
   logic [sva_pkg::OPCODE_W-1:0] req_opcode     = '0;
   logic [sva_pkg::TONE_W-1:0]   req_note_tone  = '0;
   logic                         rsp_valid;
   logic                         rsp_ready      = 1'b0;
   logic [sva_pkg::VOICE_W-1:0]  rsp_assigned_voice;
   logic                         rsp_assigned_valid;
   logic                         rsp_note_dropped;
   logic [sva_pkg::MASK_W-1:0]   rsp_released_mask;
   logic [sva_pkg::MASK_W-1:0]   rsp_active_mask;
   logic                         csr_valid      = 1'b0;
   logic                         csr_ready;
   logic [sva_pkg::MODE_W-1:0]   csr_voice_mode = '0;

   // expected result pinned to the word currently on the request port
   logic                  pin_on   = 1'b0;
   sva_pkg::rsp_word_type pin_word = '0;

   // model of the voice table
   logic [sva_pkg::TONE_W-1:0] tone_held [VOICES];
   logic [VOICES-1:0]          voice_on  = '0;
   logic [sva_pkg::MODE_W-1:0] mode_now  = sva_pkg::MODE_POLY;

   sva_pkg::rsp_word_type voice_reports [$];

   int unsigned mismatches      = 0;
   int unsigned words_accepted  = 0;
   int unsigned words_checked   = 0;
   int unsigned notes_dropped   = 0;
   int unsigned release_words   = 0;
   int unsigned full_table_hits = 0;
   int unsigned cycle_count     = 0;
   int unsigned mode_writes     = 0;

   int unsigned       stall_run  = 0;
   logic [31:0]       stall_bits = '1;
   plan_row_type      directed_plan [18];

   synth_voice_allocator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_note_tone      (req_note_tone),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_assigned_voice (rsp_assigned_voice),
      .rsp_assigned_valid (rsp_assigned_valid),
      .rsp_note_dropped   (rsp_note_dropped),
      .rsp_released_mask  (rsp_released_mask),
      .rsp_active_mask    (rsp_active_mask),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_voice_mode     (csr_voice_mode)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // release every sounding voice that holds the tone
   function automatic logic [VOICES-1:0] free_tone(logic [sva_pkg::TONE_W-1:0] tone);
      logic [VOICES-1:0] freed;
      int                v;
      freed = '0;
      for (v = 0; v < VOICES; v++) begin
         if (voice_on[v] && tone_held[v] == tone) begin
            voice_on[v] = 1'b0;
            freed[v]    = 1'b1;
         end
      end
      return freed;
   endfunction

   // apply one note event to the table and return its report
   function automatic sva_pkg::rsp_word_type play_note_event(
      logic [sva_pkg::OPCODE_W-1:0] op,
      logic [sva_pkg::TONE_W-1:0]   tone);
      sva_pkg::rsp_word_type r;
      logic                  found;
      int                    v;
      r     = '0;
      found = 1'b0;
      case (op)
         sva_pkg::OP_NOTE_ON: begin
            if (mode_now == sva_pkg::MODE_MONO) begin
               r.released_mask = free_tone(tone);
            end
            for (v = 0; v < VOICES; v++) begin
               if (!found && !voice_on[v]) begin
                  tone_held[v]     = tone;
                  voice_on[v]      = 1'b1;
                  r.assigned_voice = v[sva_pkg::VOICE_W-1:0];
                  found            = 1'b1;
               end
            end
            r.assigned_valid = found;
            r.note_dropped   = !found;
         end
         sva_pkg::OP_NOTE_OFF: begin
            if (mode_now != sva_pkg::MODE_ONESHOT) begin
               r.released_mask = free_tone(tone);
            end
         end
         sva_pkg::OP_ALL_OFF: begin
            r.released_mask = voice_on;
            voice_on        = '0;
         end
         default: begin
         end
      endcase
      r.active_mask = voice_on;
      return r;
   endfunction

   function automatic plan_row_type mode_row(logic [sva_pkg::MODE_W-1:0] m);
      plan_row_type row;
      row         = '0;
      row.is_mode = 1'b1;
      row.code    = m;
      return row;
   endfunction

   function automatic plan_row_type note_row(logic [sva_pkg::OPCODE_W-1:0] op,
                                             logic [sva_pkg::TONE_W-1:0] tone,
                                             logic [4:0] reps);
      plan_row_type row;
      row         = '0;
      row.code    = op;
      row.tone    = tone;
      row.repeats = reps;
      return row;
   endfunction

   function automatic plan_row_type fixed_row(logic [sva_pkg::OPCODE_W-1:0] op,
                                              logic [sva_pkg::TONE_W-1:0] tone,
                                              logic [sva_pkg::VOICE_W-1:0] voice,
                                              logic got_voice, logic dropped,
                                              logic [sva_pkg::MASK_W-1:0] released,
                                              logic [sva_pkg::MASK_W-1:0] active);
      plan_row_type row;
      row        = note_row(op, tone, 5'd1);
      row.pinned = 1'b1;
      row.report = '{voice, got_voice, dropped, released, active};
      return row;
   endfunction

   task automatic report_field(string name, field_type want, field_type got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // track the mode, predict each accepted word and check each result word
   always @(posedge clock) begin
      sva_pkg::rsp_word_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            mode_now = csr_voice_mode;
            mode_writes++;
         end
         if (req_valid && req_ready) begin
            want = play_note_event(req_opcode, req_note_tone);
            if (pin_on) begin
               want = pin_word;
            end
            voice_reports.push_back(want);
            words_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (voice_reports.size() == 0) begin
               $display("%0t: result word with none pending, got voice %0h active %0h",
                        $time, rsp_assigned_voice, rsp_active_mask);
               mismatches++;
            end else begin
               want = voice_reports.pop_front();
               report_field("assigned_voice", field_type'(want.assigned_voice),
                            field_type'(rsp_assigned_voice));
               report_field("assigned_valid", field_type'(want.assigned_valid),
                            field_type'(rsp_assigned_valid));
               report_field("note_dropped", field_type'(want.note_dropped),
                            field_type'(rsp_note_dropped));
               report_field("released_mask", want.released_mask, rsp_released_mask);
               report_field("active_mask", want.active_mask, rsp_active_mask);
               words_checked++;
               if (rsp_note_dropped) notes_dropped++;
               if (rsp_released_mask != '0) release_words++;
               if (rsp_active_mask == '1) full_table_hits++;
            end
         end
      end
   end

   // receiver: stretches of full rate between rotating stall patterns
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_run  <= $urandom_range(16, 96);
         stall_bits <= ($urandom_range(0, 3) == 0) ? '1 : $urandom;
         rsp_ready  <= 1'b1;
      end else begin
         stall_run  <= stall_run - 1;
         stall_bits <= {stall_bits[30:0], stall_bits[31]};
         rsp_ready  <= stall_bits[0];
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run stalled with %0d result words pending",
                  $time, voice_reports.size());
         $display("FAIL");
         $finish;
      end
   end

   // present one event word and hold it until accepted
   task automatic send_event(logic [sva_pkg::OPCODE_W-1:0] op,
                             logic [sva_pkg::TONE_W-1:0] tone,
                             logic pinned, sva_pkg::rsp_word_type report);
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_note_tone <= tone;
      pin_on        <= pinned;
      pin_word      <= report;
      do @(posedge clock); while (!req_ready);
   endtask

   // drain the pipe, then write the voice mode
   task automatic write_mode(logic [sva_pkg::MODE_W-1:0] m);
      req_valid <= 1'b0;
      @(posedge clock);
      while (voice_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_voice_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [sva_pkg::MODE_W-1:0]   mode_seq [8];
      logic [sva_pkg::OPCODE_W-1:0] op;
      logic [sva_pkg::TONE_W-1:0]   tone;
      int unsigned                  on_pct;
      int unsigned                  pick;
      int unsigned                  tone_pick;
      int unsigned                  burst_left;
      logic                         gaps_on;
      int                           p;
      int                           i;

      directed_plan = '{
         // empty table: off and all-off release nothing
         fixed_row(sva_pkg::OP_NOTE_OFF, 7'd0,   4'd0, 1'b0, 1'b0, 16'h0000, 16'h0000),
         fixed_row(sva_pkg::OP_ALL_OFF,  7'd0,   4'd0, 1'b0, 1'b0, 16'h0000, 16'h0000),
         // lowest free voice, duplicate tones allowed in polyphonic mode
         fixed_row(sva_pkg::OP_NOTE_ON,  7'd0,   4'd0, 1'b1, 1'b0, 16'h0000, 16'h0001),
         fixed_row(sva_pkg::OP_NOTE_ON,  7'd127, 4'd1, 1'b1, 1'b0, 16'h0000, 16'h0003),
         fixed_row(sva_pkg::OP_NOTE_ON,  7'd0,   4'd2, 1'b1, 1'b0, 16'h0000, 16'h0007),
         fixed_row(sva_pkg::OP_NOTE_OFF, 7'd0,   4'd0, 1'b0, 1'b0, 16'h0005, 16'h0002),
         // fill the table, then drop a note and ignore a word on a full table
         note_row(sva_pkg::OP_NOTE_ON, 7'd42, 5'd15),
         fixed_row(sva_pkg::OP_NOTE_ON,  7'd99,  4'd0, 1'b0, 1'b1, 16'h0000, 16'hFFFF),
         fixed_row(sva_pkg::OP_IGNORED,  7'd127, 4'd0, 1'b0, 1'b0, 16'h0000, 16'hFFFF),
         fixed_row(sva_pkg::OP_ALL_OFF,  7'd0,   4'd0, 1'b0, 1'b0, 16'hFFFF, 16'h0000),
         // monophonic retrigger takes back the voice it just freed
         mode_row(sva_pkg::MODE_MONO),
         fixed_row(sva_pkg::OP_NOTE_ON,  7'd5,   4'd0, 1'b1, 1'b0, 16'h0000, 16'h0001),
         fixed_row(sva_pkg::OP_NOTE_ON,  7'd5,   4'd0, 1'b1, 1'b0, 16'h0001, 16'h0001),
         // one-shot ignores note-off
         mode_row(sva_pkg::MODE_ONESHOT),
         fixed_row(sva_pkg::OP_NOTE_OFF, 7'd5,   4'd0, 1'b0, 1'b0, 16'h0000, 16'h0001),
         // spare mode code acts as polyphonic
         mode_row(MODE_SPARE),
         fixed_row(sva_pkg::OP_NOTE_ON,  7'd5,   4'd1, 1'b1, 1'b0, 16'h0000, 16'h0003),
         fixed_row(sva_pkg::OP_ALL_OFF,  7'd0,   4'd0, 1'b0, 1'b0, 16'h0003, 16'h0000)
      };
      mode_seq = '{sva_pkg::MODE_MONO, sva_pkg::MODE_ONESHOT, MODE_SPARE,
                   sva_pkg::MODE_POLY, sva_pkg::MODE_MONO, sva_pkg::MODE_ONESHOT,
                   sva_pkg::MODE_POLY, MODE_SPARE};

      // hold reset, then release it on a clock edge
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (directed_plan[r]) begin
         if (directed_plan[r].is_mode) begin
            write_mode(directed_plan[r].code);
         end else begin
            repeat (directed_plan[r].repeats) begin
               send_event(directed_plan[r].code, directed_plan[r].tone,
                          directed_plan[r].pinned, directed_plan[r].report);
            end
         end
      end

      // random events under each mode; mostly note traffic on tones drawn from the
      // full range, so that voices fill up and get released
      burst_left = 0;
      for (p = 0; p < 8; p++) begin
         write_mode(mode_seq[p]);
         gaps_on = (p % 3 != 0);
         on_pct  = $urandom_range(35, 75);
         for (i = 0; i < EVENTS_PER_MODE; i++) begin
            if (gaps_on && burst_left == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
               burst_left = $urandom_range(1, 24);
            end
            pick = $urandom_range(0, 99);
            if (pick < on_pct) op = sva_pkg::OP_NOTE_ON;
            else if (pick < 92) op = sva_pkg::OP_NOTE_OFF;
            else if (pick < 96) op = sva_pkg::OP_ALL_OFF;
            else op = sva_pkg::OP_IGNORED;
            if ($urandom_range(0, 1) == 0) tone_pick = $urandom_range(0, 127);
            else tone_pick = $urandom_range(0, 120) + $urandom_range(0, 7);
            tone = tone_pick[sva_pkg::TONE_W-1:0];
            send_event(op, tone, 1'b0, '0);
            if (burst_left != 0) burst_left--;
         end
      end

      // drain and let the pipe settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (voice_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d event words and %0d result words over %0d mode writes.",
               words_accepted, words_checked, mode_writes);
      $display("Saw %0d dropped notes, %0d words with releases, %0d with a full table.",
               notes_dropped, release_words, full_table_hits);
      if (mismatches == 0 && voice_reports.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/sva_pkg.sv
hw/rtl/sva_event.sv
hw/rtl/synth_voice_allocator.sv
bench/synth_voice_allocator_tb.sv
